@@ design/att_pkg.sv @@
// Shared codes, payload types and defaults for the animation timeline timer.
`timescale 1ns / 1ps

package att_pkg;

    localparam int TIME_BITS_DEF = 32;

    // command kinds
    localparam logic [2:0] KIND_TICK         = 3'd0;
    localparam logic [2:0] KIND_PLAY         = 3'd1;
    localparam logic [2:0] KIND_PAUSE        = 3'd2;
    localparam logic [2:0] KIND_STOP         = 3'd3;
    localparam logic [2:0] KIND_RESTART      = 3'd4;
    localparam logic [2:0] KIND_RESTART_HERE = 3'd5;
    localparam logic [2:0] KIND_JUMP_END     = 3'd6;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PLAYED    = 3'd1;
    localparam logic [2:0] EV_PAUSED    = 3'd2;
    localparam logic [2:0] EV_STOPPED   = 3'd3;
    localparam logic [2:0] EV_RESTARTED = 3'd4;
    localparam logic [2:0] EV_FINISHED  = 3'd5;
    localparam logic [2:0] EV_ADVANCED  = 3'd6;

    // run states
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_PLAYING = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;
    localparam logic [1:0] MODE_DONE    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_DURATION      = 2'd0;
    localparam logic [1:0] REG_LOOP_ENABLE   = 2'd1;
    localparam logic [1:0] REG_AUTO_REVERSE  = 2'd2;
    localparam logic [1:0] REG_START_REVERSE = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [1:0]  run_state;
        logic        going_reverse;
        logic [31:0] position;
    } t_result;

endpackage

@@ design/att_stream_if.sv @@
// Valid/ready stream channel carrying one payload type.
`timescale 1ns / 1ps

interface att_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/animation_timeline_timer_unit.sv @@
// Top level of the animation timeline timer: command stream in, event stream out.
`timescale 1ns / 1ps

//  channel   dir   payload                                         handshake
//  i_cmd     in    kind, elapsed                                   valid/ready
//  o_res     out   event_code, run_state, going_reverse, position  valid/ready
//  apb       in    duration, loop, auto reverse, start reverse     psel/penable/pready
//
//  One request per cycle sustained while results are taken; an accepted request passes
//  through the command register, then the result register, where the result is valid.
//  All state updates in one add/subtract and compare between those registers.
//  Reset is synchronous and clears configuration, state and valid flags; the payload
//  registers are not reset. A stalled result holds and backs up into the command register.

module animation_timeline_timer_unit #(
    parameter  int TIME_BITS     = att_pkg::TIME_BITS_DEF,
    localparam int P_DATA_W      = (TIME_BITS > 32) ? 64 : 32,
    localparam int P_STRIDE_BITS = (TIME_BITS > 32) ? 3 : 2,
    localparam int P_ADDR_W      = P_STRIDE_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    att_stream_if.sink           i_cmd,
    att_stream_if.source         o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [P_ADDR_W-1:0]  paddr,
    input  logic [P_DATA_W-1:0]  pwdata,
    output logic [P_DATA_W-1:0]  prdata,
    output logic                 pready
);

    // configuration
    logic [TIME_BITS-1:0] r_dur;
    logic                 r_loop;
    logic                 r_auto;
    logic                 r_start_rev;

    // timeline state
    logic [1:0]           r_mode, n_mode;
    logic                 r_rev, n_rev;
    logic [TIME_BITS-1:0] r_pos, n_pos;

    // pipeline registers
    logic                 r_in_valid;
    att_pkg::t_cmd        r_in;
    logic                 r_out_valid;
    att_pkg::t_result     r_out;

    logic                 w_cfg_wr;
    logic [1:0]           w_cfg_idx;
    logic                 w_adv;
    logic [2:0]           w_ev;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[P_ADDR_W-1:P_STRIDE_BITS];

    always_comb begin
        case (w_cfg_idx)
            att_pkg::REG_DURATION:      prdata = P_DATA_W'(r_dur);
            att_pkg::REG_LOOP_ENABLE:   prdata = P_DATA_W'(r_loop);
            att_pkg::REG_AUTO_REVERSE:  prdata = P_DATA_W'(r_auto);
            att_pkg::REG_START_REVERSE: prdata = P_DATA_W'(r_start_rev);
            default:                    prdata = '0;
        endcase
    end

    // advance the command into the result register when that register frees up
    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        logic [TIME_BITS-1:0] e;
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] p;

        e      = TIME_BITS'(r_in.elapsed);
        sum    = {1'b0, r_pos} + {1'b0, e};
        p      = r_pos;
        n_mode = r_mode;
        n_rev  = r_rev;
        n_pos  = r_pos;
        w_ev   = att_pkg::EV_NONE;

        case (r_in.kind)
            att_pkg::KIND_TICK: begin
                if (r_mode == att_pkg::MODE_PLAYING) begin
                    if (!r_rev) begin
                        // saturate at the duration, also on carry out
                        if (sum[TIME_BITS] || (sum[TIME_BITS-1:0] > r_dur)) begin
                            p = r_dur;
                        end else begin
                            p = sum[TIME_BITS-1:0];
                        end
                        n_pos = p;
                        if (p != r_dur) begin
                            w_ev = att_pkg::EV_ADVANCED;
                        end else begin
                            w_ev = att_pkg::EV_FINISHED;
                            if (r_loop) begin
                                if (r_auto) begin
                                    n_rev = 1'b1;
                                end else begin
                                    n_pos = '0;
                                end
                            end else begin
                                n_mode = att_pkg::MODE_DONE;
                            end
                        end
                    end else begin
                        if (e >= r_pos) begin
                            p = '0;
                        end else begin
                            p = r_pos - e;
                        end
                        // clamp a position left above a lowered duration
                        if (p > r_dur) begin
                            p = r_dur;
                        end
                        n_pos = p;
                        if (p != '0) begin
                            w_ev = att_pkg::EV_ADVANCED;
                        end else begin
                            w_ev = att_pkg::EV_FINISHED;
                            if (r_loop) begin
                                if (r_auto) begin
                                    n_rev = 1'b0;
                                end else begin
                                    n_pos = r_dur;
                                end
                            end else begin
                                n_mode = att_pkg::MODE_DONE;
                            end
                        end
                    end
                end
            end
            att_pkg::KIND_PLAY: begin
                if (r_mode != att_pkg::MODE_DONE && r_mode != att_pkg::MODE_PLAYING) begin
                    n_mode = att_pkg::MODE_PLAYING;
                    w_ev   = att_pkg::EV_PLAYED;
                end
            end
            att_pkg::KIND_PAUSE: begin
                n_mode = att_pkg::MODE_PAUSED;
                w_ev   = att_pkg::EV_PAUSED;
            end
            att_pkg::KIND_STOP: begin
                n_mode = att_pkg::MODE_IDLE;
                n_pos  = '0;
                w_ev   = att_pkg::EV_STOPPED;
            end
            att_pkg::KIND_RESTART: begin
                n_mode = att_pkg::MODE_PLAYING;
                n_pos  = r_rev ? r_dur : '0;
                w_ev   = att_pkg::EV_RESTARTED;
            end
            att_pkg::KIND_RESTART_HERE: begin
                n_mode = att_pkg::MODE_PLAYING;
                w_ev   = att_pkg::EV_RESTARTED;
            end
            att_pkg::KIND_JUMP_END: begin
                n_pos = r_dur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur       <= '0;
            r_loop      <= 1'b0;
            r_auto      <= 1'b0;
            r_start_rev <= 1'b0;
            r_mode      <= att_pkg::MODE_IDLE;
            r_rev       <= 1'b0;
            r_pos       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_mode <= n_mode;
                r_pos  <= n_pos;
            end
            // a start reverse write loads the direction as well
            if (w_cfg_wr && (w_cfg_idx == att_pkg::REG_START_REVERSE)) begin
                r_rev <= pwdata[0];
            end else if (w_adv) begin
                r_rev <= n_rev;
            end
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    att_pkg::REG_DURATION:      r_dur       <= TIME_BITS'(pwdata);
                    att_pkg::REG_LOOP_ENABLE:   r_loop      <= pwdata[0];
                    att_pkg::REG_AUTO_REVERSE:  r_auto      <= pwdata[0];
                    att_pkg::REG_START_REVERSE: r_start_rev <= pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
        if (w_adv) begin
            r_out.event_code    <= w_ev;
            r_out.run_state     <= n_mode;
            r_out.going_reverse <= n_rev;
            r_out.position      <= 32'(n_pos);
        end
    end

    a_start_rev_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr && (w_cfg_idx == att_pkg::REG_START_REVERSE) |=> r_rev == $past(pwdata[0]))
        else $error("direction not loaded by start reverse write");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_in.kind == att_pkg::KIND_STOP)
        |=> (r_pos == '0) && (r_mode == att_pkg::MODE_IDLE))
        else $error("stop did not clear position and state");

    a_advanced_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.event_code == att_pkg::EV_ADVANCED)
        |-> r_out.run_state == att_pkg::MODE_PLAYING)
        else $error("advanced event outside playing");

    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (w_ev == att_pkg::EV_FINISHED) && !r_loop
        |=> r_mode == att_pkg::MODE_DONE)
        else $error("finish without looping did not reach done");

    a_fwd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (w_ev == att_pkg::EV_ADVANCED) |-> n_pos <= r_dur)
        else $error("tick left position above duration");

endmodule

@@ bench/tb_animation_timeline_timer_unit.sv @@
// Self-checking bench for the animation timeline timer: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_animation_timeline_timer_unit;

    localparam logic [2:0] KIND_UNUSED   = 3'd7;
    localparam int         DRAIN_CYCLES  = 4;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASES        = 10;
    localparam int         PHASE_ITEMS   = 150;
    localparam int         HOLD_AT       = 400;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         CALM_FROM     = 700;
    localparam int         CALM_TO       = 950;
    localparam int         IDLE_PCT      = 17;
    localparam int         REPORT_MAX    = 10;

    typedef struct {
        bit               is_reg;
        logic [1:0]       reg_idx;
        logic [31:0]      reg_val;
        att_pkg::t_cmd    cmd;
        bit               typed;
        att_pkg::t_result want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    att_stream_if #(.T(att_pkg::t_cmd))    cmd_if ();
    att_stream_if #(.T(att_pkg::t_result)) res_if ();

    animation_timeline_timer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // timeline state as the block should hold it
    logic [31:0] tl_dur;
    logic        tl_loop;
    logic        tl_arev;
    logic        tl_srev;
    logic [1:0]  tl_mode;
    logic        tl_rev;
    logic [31:0] tl_pos;

    att_pkg::t_result expected_events[$];
    t_step   plan[$];
    int      n_sent = 0;
    int      n_fail = 0;
    int      hold_left = 0;
    bit      hold_taken = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit in_calm();
        return (n_sent >= CALM_FROM) && (n_sent < CALM_TO);
    endfunction

    task automatic note_failure(input string msg);
        if (n_fail < REPORT_MAX) $display("ERROR: %s", msg);
        n_fail++;
    endtask

    function automatic void set_timeline_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            att_pkg::REG_DURATION:      tl_dur  = val;
            att_pkg::REG_LOOP_ENABLE:   tl_loop = val[0];
            att_pkg::REG_AUTO_REVERSE:  tl_arev = val[0];
            att_pkg::REG_START_REVERSE: begin
                tl_srev = val[0];
                tl_rev  = val[0];
            end
            default: ;
        endcase
    endfunction

    // end of travel: flip, wrap or finish
    function automatic void hit_end();
        if (tl_loop) begin
            if (tl_arev) tl_rev = ~tl_rev;
            else tl_pos = tl_rev ? tl_dur : 32'd0;
        end else begin
            tl_mode = att_pkg::MODE_DONE;
        end
    endfunction

    function automatic att_pkg::t_result step_timeline(input att_pkg::t_cmd c);
        logic [32:0]      sum;
        logic [31:0]      np;
        logic [2:0]       ev;
        att_pkg::t_result r;
        ev = att_pkg::EV_NONE;
        case (c.kind)
            att_pkg::KIND_TICK: begin
                if (tl_mode == att_pkg::MODE_PLAYING) begin
                    if (!tl_rev) begin
                        sum = {1'b0, tl_pos} + {1'b0, c.elapsed};
                        np  = (sum[32] || sum[31:0] > tl_dur) ? tl_dur : sum[31:0];
                        tl_pos = np;
                        ev = (np != tl_dur) ? att_pkg::EV_ADVANCED : att_pkg::EV_FINISHED;
                    end else begin
                        np = (c.elapsed >= tl_pos) ? 32'd0 : tl_pos - c.elapsed;
                        if (np > tl_dur) np = tl_dur;
                        tl_pos = np;
                        ev = (np != 32'd0) ? att_pkg::EV_ADVANCED : att_pkg::EV_FINISHED;
                    end
                    if (ev == att_pkg::EV_FINISHED) hit_end();
                end
            end
            att_pkg::KIND_PLAY: begin
                if (tl_mode != att_pkg::MODE_DONE && tl_mode != att_pkg::MODE_PLAYING) begin
                    tl_mode = att_pkg::MODE_PLAYING;
                    ev = att_pkg::EV_PLAYED;
                end
            end
            att_pkg::KIND_PAUSE: begin
                tl_mode = att_pkg::MODE_PAUSED;
                ev = att_pkg::EV_PAUSED;
            end
            att_pkg::KIND_STOP: begin
                tl_mode = att_pkg::MODE_IDLE;
                tl_pos = 32'd0;
                ev = att_pkg::EV_STOPPED;
            end
            att_pkg::KIND_RESTART: begin
                tl_mode = att_pkg::MODE_PLAYING;
                tl_pos = tl_rev ? tl_dur : 32'd0;
                ev = att_pkg::EV_RESTARTED;
            end
            att_pkg::KIND_RESTART_HERE: begin
                tl_mode = att_pkg::MODE_PLAYING;
                ev = att_pkg::EV_RESTARTED;
            end
            att_pkg::KIND_JUMP_END: tl_pos = tl_dur;
            default: ;
        endcase
        r.event_code    = ev;
        r.run_state     = tl_mode;
        r.going_reverse = tl_rev;
        r.position      = tl_pos;
        return r;
    endfunction

    function automatic t_step row_cmd(input logic [2:0] kind, input logic [31:0] elapsed);
        t_step s;
        s = '{default: '0};
        s.cmd.kind    = kind;
        s.cmd.elapsed = elapsed;
        return s;
    endfunction

    function automatic t_step row_chk(input logic [2:0] kind, input logic [31:0] elapsed,
                                      input logic [2:0] ev, input logic [1:0] st,
                                      input logic rev, input logic [31:0] pos);
        t_step s;
        s = row_cmd(kind, elapsed);
        s.typed = 1'b1;
        s.want.event_code    = ev;
        s.want.run_state     = st;
        s.want.going_reverse = rev;
        s.want.position      = pos;
        return s;
    endfunction

    function automatic t_step row_reg(input logic [1:0] idx, input logic [31:0] val);
        t_step s;
        s = '{default: '0};
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    task automatic push_cmd(input att_pkg::t_cmd c, input bit typed,
                            input att_pkg::t_result want);
        att_pkg::t_result pred;
        while (!in_calm() && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pred = step_timeline(c);
        expected_events.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // hold commands until every request has come back
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_timeline_reg(idx, val);
    endtask

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 16);
            3, 4:    return $urandom_range(17, 4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return tl_dur;
            3:       return tl_dur + 32'd1;
            4, 5, 6: return $urandom_range(0, tl_dur / 8 + 1);
            7:       return $urandom;
            8:       return $urandom_range(1, 16);
            default: return tl_dur - $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return att_pkg::KIND_TICK;
        if (r < 65) return att_pkg::KIND_PLAY;
        if (r < 71) return att_pkg::KIND_PAUSE;
        if (r < 76) return att_pkg::KIND_STOP;
        if (r < 83) return att_pkg::KIND_RESTART;
        if (r < 89) return att_pkg::KIND_RESTART_HERE;
        if (r < 96) return att_pkg::KIND_JUMP_END;
        return KIND_UNUSED;
    endfunction

    function automatic logic [31:0] flag_word(input logic b);
        return ($urandom & 32'hFFFF_FFFE) | {31'd0, b};
    endfunction

    // receiver: random back-pressure, one long hold-off, one calm stretch
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (!hold_taken && n_sent >= HOLD_AT) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= in_calm() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_results
        att_pkg::t_result want;
        att_pkg::t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (expected_events.size() == 0) begin
                note_failure($sformatf("unexpected result %p", got));
            end else begin
                want = expected_events.pop_front();
                if (got.event_code !== want.event_code || got.run_state !== want.run_state ||
                    got.going_reverse !== want.going_reverse ||
                    got.position !== want.position) begin
                    note_failure($sformatf({"mismatch: expected ev=%0d st=%0d rev=%0d ",
                        "pos=%0h, got ev=%0d st=%0d rev=%0d pos=%0h"},
                        want.event_code, want.run_state, want.going_reverse, want.position,
                        got.event_code, got.run_state, got.going_reverse, got.position));
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL animation_timeline_timer_unit");
        $finish;
    end

    initial begin : stimulus
        att_pkg::t_cmd    c;
        att_pkg::t_result none;
        none = '0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        tl_dur  = '0;
        tl_loop = 1'b0;
        tl_arev = 1'b0;
        tl_srev = 1'b0;
        tl_mode = att_pkg::MODE_IDLE;
        tl_rev  = 1'b0;
        tl_pos  = '0;

        // zero duration right after reset
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'd5,
            att_pkg::EV_NONE, att_pkg::MODE_IDLE, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_PLAY, 32'd0,
            att_pkg::EV_PLAYED, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'd0,
            att_pkg::EV_FINISHED, att_pkg::MODE_DONE, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_PLAY, 32'd0,
            att_pkg::EV_NONE, att_pkg::MODE_DONE, 1'b0, 32'd0));
        plan.push_back(row_chk(KIND_UNUSED, 32'hFFFF_FFFF,
            att_pkg::EV_NONE, att_pkg::MODE_DONE, 1'b0, 32'd0));
        plan.push_back(row_reg(att_pkg::REG_DURATION, 32'd1000));
        plan.push_back(row_chk(att_pkg::KIND_RESTART, 32'd0,
            att_pkg::EV_RESTARTED, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'hFFFF_FFFF,
            att_pkg::EV_FINISHED, att_pkg::MODE_DONE, 1'b0, 32'd1000));
        plan.push_back(row_chk(att_pkg::KIND_PAUSE, 32'd0,
            att_pkg::EV_PAUSED, att_pkg::MODE_PAUSED, 1'b0, 32'd1000));
        plan.push_back(row_chk(att_pkg::KIND_PLAY, 32'd0,
            att_pkg::EV_PLAYED, att_pkg::MODE_PLAYING, 1'b0, 32'd1000));
        plan.push_back(row_chk(att_pkg::KIND_STOP, 32'd0,
            att_pkg::EV_STOPPED, att_pkg::MODE_IDLE, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_PLAY, 32'd0,
            att_pkg::EV_PLAYED, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_PLAY, 32'd0,
            att_pkg::EV_NONE, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_cmd(att_pkg::KIND_TICK, 32'd300));
        plan.push_back(row_chk(att_pkg::KIND_JUMP_END, 32'd0,
            att_pkg::EV_NONE, att_pkg::MODE_PLAYING, 1'b0, 32'd1000));
        // lower the duration under the position: next tick clamps
        plan.push_back(row_reg(att_pkg::REG_DURATION, 32'd500));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'd1,
            att_pkg::EV_FINISHED, att_pkg::MODE_DONE, 1'b0, 32'd500));
        plan.push_back(row_reg(att_pkg::REG_LOOP_ENABLE,   32'd1));
        plan.push_back(row_reg(att_pkg::REG_AUTO_REVERSE,  32'd1));
        plan.push_back(row_reg(att_pkg::REG_START_REVERSE, 32'd1));
        plan.push_back(row_chk(att_pkg::KIND_RESTART, 32'd0,
            att_pkg::EV_RESTARTED, att_pkg::MODE_PLAYING, 1'b1, 32'd500));
        plan.push_back(row_cmd(att_pkg::KIND_TICK, 32'd200));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'hFFFF_FFFF,
            att_pkg::EV_FINISHED, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'hFFFF_FFFF,
            att_pkg::EV_FINISHED, att_pkg::MODE_PLAYING, 1'b1, 32'd500));
        plan.push_back(row_reg(att_pkg::REG_AUTO_REVERSE, 32'd0));
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'd500,
            att_pkg::EV_FINISHED, att_pkg::MODE_PLAYING, 1'b1, 32'd500));
        plan.push_back(row_chk(att_pkg::KIND_RESTART_HERE, 32'd0,
            att_pkg::EV_RESTARTED, att_pkg::MODE_PLAYING, 1'b1, 32'd500));
        plan.push_back(row_reg(att_pkg::REG_START_REVERSE, 32'd0));
        plan.push_back(row_reg(att_pkg::REG_DURATION, 32'hFFFF_FFFF));
        // forward overflow saturates at the duration, then wraps
        plan.push_back(row_chk(att_pkg::KIND_TICK, 32'hFFFF_FFFF,
            att_pkg::EV_FINISHED, att_pkg::MODE_PLAYING, 1'b0, 32'd0));
        plan.push_back(row_cmd(att_pkg::KIND_TICK,  32'h8000_0000));
        plan.push_back(row_cmd(att_pkg::KIND_PAUSE, 32'h7FFF_FFFF));
        plan.push_back(row_cmd(att_pkg::KIND_TICK,  32'h5555_5555));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                apb_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) apb_write(att_pkg::REG_DURATION, 32'd0);
            else if (ph == 1) apb_write(att_pkg::REG_DURATION, 32'hFFFF_FFFF);
            else apb_write(att_pkg::REG_DURATION, pick_duration());
            if ($urandom_range(0, 1))
                apb_write(att_pkg::REG_LOOP_ENABLE, flag_word($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                apb_write(att_pkg::REG_AUTO_REVERSE, flag_word($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                apb_write(att_pkg::REG_START_REVERSE, flag_word($urandom_range(0, 1)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                c.kind    = pick_kind();
                c.elapsed = (c.kind == att_pkg::KIND_TICK) ? pick_elapsed() : $urandom;
                push_cmd(c, 1'b0, none);
            end
        end

        settle();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS animation_timeline_timer_unit");
        end else begin
            $display("FAIL animation_timeline_timer_unit");
        end
        $finish;
    end

endmodule
